// File: src/mer_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mer_pkg
// Shared types, widths and state codes for the midpoint ellipse rasterizer.
// ---------------------------------------------------------------------------
package mer_pkg;

  localparam int RADIUS_BITS = 9;
  localparam int COORD_BITS  = 10;
  localparam int OUT_W       = 12;

  localparam int X_W    = RADIUS_BITS + 1;
  localparam int Y_W    = RADIUS_BITS + 2;
  localparam int SQ_W   = 2 * RADIUS_BITS;
  localparam int MA_W   = 2 * RADIUS_BITS + 4;
  localparam int MB_W   = 2 * RADIUS_BITS;
  localparam int P_W    = MA_W + MB_W;
  localparam int GAIN_W = 3 * RADIUS_BITS + 4;
  localparam int DEC_W  = 4 * RADIUS_BITS + 8;
  localparam int CALC_W = 16;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius_x;
    logic [RADIUS_BITS-1:0] radius_y;
  } mer_req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] right_x;
    logic signed [OUT_W-1:0] left_x;
    logic signed [OUT_W-1:0] lower_y;
    logic signed [OUT_W-1:0] upper_y;
    logic                    last;
  } mer_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT0,
    ST_INIT1,
    ST_INIT2,
    ST_INIT3,
    ST_SETTLE,
    ST_R2_0,
    ST_R2_1,
    ST_R2_2,
    ST_R2_3,
    ST_R2_4,
    ST_R2_5,
    ST_STEP_A,
    ST_STEP_B,
    ST_EMIT
  } mer_state_e;

endpackage
`default_nettype wire

// File: src/midpoint_ellipse_rasterizer_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_top
// Midpoint ellipse rasterizer with valid/ready request and result channels.
// ---------------------------------------------------------------------------
// A start request (kind 0) latches center and radii and primes the decision
// value on one shared multiplier; the next request is taken only once this
// is done, also when region 2 is entered at once (zero radius).
// A step request (kind 1) produces one result holding the four mirrored
// coordinates of the current point, then advances it with adds only; on
// the step that crosses into region 2 the decision value is recomputed
// through five multiplier passes. A step while no ellipse is active gives
// no result. The final point carries last.
// Results sit in an output register, so the next request is taken while a
// result still waits.
module midpoint_ellipse_rasterizer_top
  import mer_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire mer_req_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output mer_rsp_t      out_data_o
);

  logic     out_valid_q, out_valid_d;
  mer_rsp_t out_q;
  logic     slot_free;
  logic     res_valid;
  mer_rsp_t res;

  assign slot_free = !out_valid_q || out_ready_i;

  mer_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .slot_free_i (slot_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: src/mer_mul.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mer_mul
// Shared unsigned multiplier with a registered product.
// ---------------------------------------------------------------------------
module mer_mul
  import mer_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic [MA_W-1:0] a_i,
  input  wire logic [MB_W-1:0] b_i,
  output logic      [P_W-1:0]  p_o
);

  logic [P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= P_W'(a_i) * P_W'(b_i);
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// File: src/mer_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mer_core
// Sequencer and datapath: primes decision values on the shared multiplier
// and walks the ellipse one point per step request.
// ---------------------------------------------------------------------------
module mer_core
  import mer_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire mer_req_t in_data_i,
  input  wire logic     slot_free_i,
  output logic          res_valid_o,
  output mer_rsp_t      res_o
);

  mer_state_e state_q, state_d;
  logic drawing_q, drawing_d;
  logic r2_q, r2_d;
  logic from_step_q, from_step_d;

  logic [COORD_BITS-1:0]  cx_q, cx_d, cy_q, cy_d;
  logic [RADIUS_BITS-1:0] rx_q, rx_d, ry_q, ry_d;
  logic [SQ_W-1:0]        rx2_q, rx2_d, ry2_q, ry2_d;
  logic [X_W-1:0]         x_q, x_d;
  logic signed [Y_W-1:0]  y_q, y_d;
  logic signed [GAIN_W-1:0] gx_q, gx_d, gy_q, gy_d;
  logic signed [DEC_W-1:0]  dec_q, dec_d;
  mer_rsp_t res_q, res_d;

  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [P_W-1:0]  prod;

  logic signed [DEC_W-1:0]  prod_ext, rx2_ext, ry2_ext, gx_ext, gy_ext, step_add;
  logic signed [GAIN_W-1:0] rx2_x2, ry2_x2;
  logic signed [Y_W:0]      ym1;
  logic [Y_W-1:0]           ym1_abs;
  logic [X_W:0]             two_x1;
  logic signed [CALC_W-1:0] cx_w, cy_w, x_w, y_w;
  logic dec_neg, dec_pos, step_x, step_y, accept;

  mer_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign prod_ext = $signed(DEC_W'(prod));
  assign rx2_ext  = $signed(DEC_W'(rx2_q));
  assign ry2_ext  = $signed(DEC_W'(ry2_q));
  assign gx_ext   = DEC_W'(gx_q);
  assign gy_ext   = DEC_W'(gy_q);
  assign rx2_x2   = $signed(GAIN_W'({rx2_q, 1'b0}));
  assign ry2_x2   = $signed(GAIN_W'({ry2_q, 1'b0}));
  assign ym1      = (Y_W+1)'(y_q) - (Y_W+1)'(1);
  assign ym1_abs  = ym1[Y_W] ? Y_W'(-ym1) : Y_W'(ym1);
  assign two_x1   = {x_q, 1'b1};

  assign dec_neg = dec_q[DEC_W-1];
  assign dec_pos = !dec_neg && (dec_q != '0);
  assign step_x  = !r2_q || !dec_pos;
  assign step_y  = r2_q || !dec_neg;
  assign step_add = (step_x ? (gx_ext <<< 2) : '0) - (step_y ? (gy_ext <<< 2) : '0)
                  + ((r2_q ? rx2_ext : ry2_ext) <<< 2);

  assign cx_w = $signed(CALC_W'(cx_q));
  assign cy_w = $signed(CALC_W'(cy_q));
  assign x_w  = $signed(CALC_W'(x_q));
  assign y_w  = CALC_W'(y_q);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == ST_EMIT) && slot_free_i;
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    drawing_d   = drawing_q;
    r2_d        = r2_q;
    from_step_d = from_step_q;
    cx_d  = cx_q;
    cy_d  = cy_q;
    rx_d  = rx_q;
    ry_d  = ry_q;
    rx2_d = rx2_q;
    ry2_d = ry2_q;
    x_d   = x_q;
    y_d   = y_q;
    gx_d  = gx_q;
    gy_d  = gy_q;
    dec_d = dec_q;
    res_d = res_q;
    mul_a = MA_W'(rx_q);
    mul_b = MB_W'(rx_q);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.kind == KIND_START) begin
            cx_d    = in_data_i.center_x;
            cy_d    = in_data_i.center_y;
            rx_d    = in_data_i.radius_x;
            ry_d    = in_data_i.radius_y;
            state_d = ST_INIT0;
          end else if (drawing_q) begin
            state_d = ST_STEP_A;
          end
        end
      end
      ST_INIT0: begin
        mul_a   = MA_W'(rx_q);
        mul_b   = MB_W'(rx_q);
        state_d = ST_INIT1;
      end
      ST_INIT1: begin
        rx2_d   = SQ_W'(prod);
        mul_a   = MA_W'(ry_q);
        mul_b   = MB_W'(ry_q);
        state_d = ST_INIT2;
      end
      ST_INIT2: begin
        ry2_d   = SQ_W'(prod);
        mul_a   = MA_W'(rx2_q);
        mul_b   = MB_W'(ry_q);
        state_d = ST_INIT3;
      end
      ST_INIT3: begin
        x_d         = '0;
        y_d         = $signed(Y_W'(ry_q));
        gx_d        = '0;
        gy_d        = $signed(GAIN_W'({prod, 1'b0}));
        dec_d       = (ry2_ext <<< 2) - (prod_ext <<< 2) + rx2_ext;
        r2_d        = 1'b0;
        from_step_d = 1'b0;
        state_d     = ST_SETTLE;
      end
      ST_SETTLE: begin
        if (!r2_q && !(gx_q < gy_q)) begin
          state_d = ST_R2_0;
        end else begin
          drawing_d = !y_q[Y_W-1];
          res_d.last = y_q[Y_W-1];
          state_d   = from_step_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_R2_0: begin
        mul_a   = MA_W'(two_x1);
        mul_b   = MB_W'(two_x1);
        state_d = ST_R2_1;
      end
      ST_R2_1: begin
        mul_a   = prod[MA_W-1:0];
        mul_b   = MB_W'(ry2_q);
        state_d = ST_R2_2;
      end
      ST_R2_2: begin
        dec_d   = prod_ext;
        mul_a   = MA_W'(ym1_abs);
        mul_b   = MB_W'(ym1_abs);
        state_d = ST_R2_3;
      end
      ST_R2_3: begin
        mul_a   = prod[MA_W-1:0];
        mul_b   = MB_W'(rx2_q);
        state_d = ST_R2_4;
      end
      ST_R2_4: begin
        dec_d   = dec_q + (prod_ext <<< 2);
        mul_a   = MA_W'(rx2_q);
        mul_b   = MB_W'(ry2_q);
        state_d = ST_R2_5;
      end
      ST_R2_5: begin
        dec_d   = dec_q - (prod_ext <<< 2);
        r2_d    = 1'b1;
        state_d = ST_SETTLE;
      end
      ST_STEP_A: begin
        res_d.right_x = OUT_W'(cx_w + x_w);
        res_d.left_x  = OUT_W'(cx_w - x_w);
        res_d.lower_y = OUT_W'(cy_w + y_w);
        res_d.upper_y = OUT_W'(cy_w - y_w);
        if (step_x) begin
          x_d  = x_q + X_W'(1);
          gx_d = gx_q + ry2_x2;
        end
        if (step_y) begin
          y_d  = y_q - Y_W'(1);
          gy_d = gy_q - rx2_x2;
        end
        state_d = ST_STEP_B;
      end
      ST_STEP_B: begin
        dec_d       = dec_q + step_add;
        from_step_d = 1'b1;
        state_d     = ST_SETTLE;
      end
      ST_EMIT: begin
        if (slot_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      drawing_q   <= 1'b0;
      r2_q        <= 1'b0;
      from_step_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      drawing_q   <= drawing_d;
      r2_q        <= r2_d;
      from_step_q <= from_step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    rx_q  <= rx_d;
    ry_q  <= ry_d;
    rx2_q <= rx2_d;
    ry2_q <= ry2_d;
    x_q   <= x_d;
    y_q   <= y_d;
    gx_q  <= gx_d;
    gy_q  <= gy_d;
    dec_q <= dec_d;
    res_q <= res_d;
  end

endmodule
`default_nettype wire

// File: bench/tb_midpoint_ellipse_rasterizer_top.sv
// ---------------------------------------------------------------------------
// tb_midpoint_ellipse_rasterizer_top
// Self-checking bench for the midpoint ellipse rasterizer. An in-bench model
// traces each ellipse from the accepted requests and queues the expected
// points. Results are checked field by field, in order. Directed tests cover
// degenerate radii, extreme geometry, idle steps and restarts. The random
// part then runs whole and truncated ellipses under bursty request traffic
// and a patterned result stall.
// ---------------------------------------------------------------------------
module tb_midpoint_ellipse_rasterizer_top;
  import mer_pkg::*;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  mer_req_t in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  mer_rsp_t out_data_o;

  midpoint_ellipse_rasterizer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Tracer state
  logic signed [Y_W:0]      pos_x;
  logic signed [Y_W:0]      pos_y;
  logic signed [GAIN_W:0]   rate_x;
  logic signed [GAIN_W:0]   rate_y;
  logic signed [DEC_W-1:0]  err_term;
  bit                       steep_side;
  bit                       tracing;
  logic [COORD_BITS-1:0]    origin_x;
  logic [COORD_BITS-1:0]    origin_y;
  logic [RADIUS_BITS-1:0]   semi_x;
  logic [RADIUS_BITS-1:0]   semi_y;

  mer_rsp_t expected_points[$];
  int       mismatches = 0;
  int       items_sent = 0;
  int       burst_left = 0;
  int       stall_mode = 0;
  int       stall_left = 0;

  function automatic bit turn_and_check();
    longint a2, b2, t;
    a2 = longint'(semi_x) * longint'(semi_x);
    b2 = longint'(semi_y) * longint'(semi_y);
    if (!steep_side && !(rate_x < rate_y)) begin
      steep_side = 1'b1;
      t = 2 * longint'(pos_x) + 1;
      err_term = DEC_W'(b2 * t * t
               + 4 * a2 * (longint'(pos_y) - 1) * (longint'(pos_y) - 1)
               - 4 * a2 * b2);
    end
    return pos_y >= 0;
  endfunction

  task automatic trace_ellipse(input mer_req_t req);
    longint   a2, b2;
    mer_rsp_t pt;
    bit       more;
    items_sent++;
    if (req.kind == KIND_START) begin
      origin_x   = req.center_x;
      origin_y   = req.center_y;
      semi_x     = req.radius_x;
      semi_y     = req.radius_y;
      a2         = longint'(semi_x) * longint'(semi_x);
      b2         = longint'(semi_y) * longint'(semi_y);
      pos_x      = '0;
      pos_y      = (Y_W+1)'(semi_y);
      rate_x     = '0;
      rate_y     = (GAIN_W+1)'(2 * a2 * longint'(semi_y));
      err_term   = DEC_W'(4 * b2 - 4 * a2 * longint'(semi_y) + a2);
      steep_side = 1'b0;
      tracing    = turn_and_check();
    end else if (tracing) begin
      pt.right_x = OUT_W'(longint'(origin_x) + longint'(pos_x));
      pt.left_x  = OUT_W'(longint'(origin_x) - longint'(pos_x));
      pt.lower_y = OUT_W'(longint'(origin_y) + longint'(pos_y));
      pt.upper_y = OUT_W'(longint'(origin_y) - longint'(pos_y));
      a2 = longint'(semi_x) * longint'(semi_x);
      b2 = longint'(semi_y) * longint'(semi_y);
      if (!steep_side) begin
        pos_x  = (Y_W+1)'(pos_x + 1);
        rate_x = (GAIN_W+1)'(rate_x + 2 * b2);
        if (err_term < 0) begin
          err_term = DEC_W'(err_term + 4 * rate_x + 4 * b2);
        end else begin
          pos_y    = (Y_W+1)'(pos_y - 1);
          rate_y   = (GAIN_W+1)'(rate_y - 2 * a2);
          err_term = DEC_W'(err_term + 4 * rate_x - 4 * rate_y + 4 * b2);
        end
      end else begin
        pos_y  = (Y_W+1)'(pos_y - 1);
        rate_y = (GAIN_W+1)'(rate_y - 2 * a2);
        if (err_term > 0) begin
          err_term = DEC_W'(err_term + 4 * a2 - 4 * rate_y);
        end else begin
          pos_x    = (Y_W+1)'(pos_x + 1);
          rate_x   = (GAIN_W+1)'(rate_x + 2 * b2);
          err_term = DEC_W'(err_term + 4 * rate_x - 4 * rate_y + 4 * a2);
        end
      end
      more    = turn_and_check();
      pt.last = !more;
      tracing = more;
      expected_points.push_back(pt);
    end
  endtask

  task automatic send_request(input mer_req_t req);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    trace_ellipse(req);
  endtask

  function automatic mer_req_t start_request(input int cx, input int cy,
                                             input int rx, input int ry);
    mer_req_t r;
    r.kind     = KIND_START;
    r.center_x = COORD_BITS'(cx);
    r.center_y = COORD_BITS'(cy);
    r.radius_x = RADIUS_BITS'(rx);
    r.radius_y = RADIUS_BITS'(ry);
    return r;
  endfunction

  // Geometry fields of a step are don't-care; keep them random.
  function automatic mer_req_t step_request();
    mer_req_t r;
    r.kind     = KIND_STEP;
    r.center_x = COORD_BITS'($urandom_range(0, 1023));
    r.center_y = COORD_BITS'($urandom_range(0, 1023));
    r.radius_x = RADIUS_BITS'($urandom_range(0, 511));
    r.radius_y = RADIUS_BITS'($urandom_range(0, 511));
    return r;
  endfunction

  task automatic run_steps(input int limit);
    int n;
    n = 0;
    while (tracing && n < limit) begin
      send_request(step_request());
      n++;
    end
  endtask

  task automatic check_field(input string name, input int exp, input int act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    mer_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_points.size() == 0) begin
        $error("result with no point expected: right_x %0d upper_y %0d",
               out_data_o.right_x, out_data_o.upper_y);
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        check_field("right_x", int'(want.right_x), int'(out_data_o.right_x));
        check_field("left_x",  int'(want.left_x),  int'(out_data_o.left_x));
        check_field("lower_y", int'(want.lower_y), int'(out_data_o.lower_y));
        check_field("upper_y", int'(want.upper_y), int'(out_data_o.upper_y));
        check_field("last",    int'(want.last),    int'(out_data_o.last));
      end
    end
  end

  // Result stall: free-flowing, random, or periodic stretches
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        out_ready_i <= 1'b1;
      end
      1: begin
        out_ready_i <= ($urandom_range(0, 2) != 0);
      end
      default: begin
        out_ready_i <= (stall_left % 4 == 0);
      end
    endcase
  end

  task automatic test_idle_steps();
    send_request(step_request());
    send_request(step_request());
  endtask

  task automatic test_degenerate_radii();
    send_request(start_request(0, 0, 0, 0));
    run_steps(4);
    send_request(step_request());
    send_request(start_request(1023, 1023, 0, 3));
    run_steps(8);
    send_request(start_request(517, 3, 5, 0));
    run_steps(4);
  endtask

  task automatic test_extreme_geometry();
    send_request(start_request(1023, 0, 2, 1));
    run_steps(10);
    send_request(start_request(0, 1023, 511, 511));
    run_steps(3);
  endtask

  task automatic test_restart();
    send_request(start_request(512, 512, 1, 1));
    run_steps(8);
  endtask

  task automatic test_random_ellipses(input int count);
    int stop_at;
    int pick;
    int rx;
    int ry;
    int steps;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_request($urandom_range(0, 1) ? step_request()
                                          : start_request($urandom_range(0, 1023),
                                                          $urandom_range(0, 1023),
                                                          $urandom_range(0, 511),
                                                          $urandom_range(0, 511)));
      end else if (pick < 22) begin
        rx = $urandom_range(0, 511);
        ry = $urandom_range(0, 511);
        send_request(start_request($urandom_range(0, 1023), $urandom_range(0, 1023),
                                   rx, ry));
        steps = (pick < 10) ? 4000 : $urandom_range(1, 80);
        run_steps((steps < stop_at - items_sent) ? steps : stop_at - items_sent);
      end else begin
        rx = $urandom_range(0, 12);
        ry = $urandom_range(0, 12);
        send_request(start_request($urandom_range(0, 1023), $urandom_range(0, 1023),
                                   rx, ry));
        run_steps(($urandom_range(0, 9) == 0) ? $urandom_range(0, 10) : 4000);
        repeat ($urandom_range(0, 2)) send_request(step_request());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_steps();
    test_degenerate_radii();
    test_extreme_geometry();
    test_restart();
    test_random_ellipses(950);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("** midpoint_ellipse_rasterizer_top: PASSED **");
    end else begin
      $display("** midpoint_ellipse_rasterizer_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("** midpoint_ellipse_rasterizer_top: FAILED **");
    $finish;
  end

endmodule
